### hdl/tcphs_pkg.sv
package tcphs_pkg;

  localparam int unsigned KindW  = 2;
  localparam int unsigned PortW  = 16;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned SeqW   = 32;
  localparam int unsigned WinW   = 16;
  localparam int unsigned RetryW = 4;
  localparam int unsigned CsumW  = 16;
  localparam int unsigned RegIdxW = 4;
  localparam int unsigned CfgDataW = 32;

  localparam logic [KindW-1:0] KIND_START   = 2'd0;
  localparam logic [KindW-1:0] KIND_SEGMENT = 2'd1;
  localparam logic [KindW-1:0] KIND_TIMEOUT = 2'd2;

  localparam logic [RegIdxW-1:0] REG_LOCAL_ADDRESS    = 4'd0;
  localparam logic [RegIdxW-1:0] REG_REMOTE_ADDRESS   = 4'd1;
  localparam logic [RegIdxW-1:0] REG_LOCAL_PORT       = 4'd2;
  localparam logic [RegIdxW-1:0] REG_REMOTE_PORT      = 4'd3;
  localparam logic [RegIdxW-1:0] REG_INITIAL_SEQUENCE = 4'd4;
  localparam logic [RegIdxW-1:0] REG_FINAL_SEQUENCE   = 4'd5;
  localparam logic [RegIdxW-1:0] REG_WINDOW_SIZE      = 4'd6;
  localparam logic [RegIdxW-1:0] REG_RETRY_LIMIT      = 4'd7;

  localparam logic [AddrW-1:0]  RST_LOCAL_ADDRESS    = 32'h7F00_0001;
  localparam logic [AddrW-1:0]  RST_REMOTE_ADDRESS   = 32'h7F00_0001;
  localparam logic [PortW-1:0]  RST_LOCAL_PORT       = 16'd1234;
  localparam logic [PortW-1:0]  RST_REMOTE_PORT      = 16'd12345;
  localparam logic [SeqW-1:0]   RST_INITIAL_SEQUENCE = 32'd200;
  localparam logic [SeqW-1:0]   RST_FINAL_SEQUENCE   = 32'd600;
  localparam logic [WinW-1:0]   RST_WINDOW_SIZE      = 16'd5840;
  localparam logic [RetryW-1:0] RST_RETRY_LIMIT      = 4'd3;

  localparam logic [7:0]  FLAG_SYN     = 8'h02;
  localparam logic [7:0]  FLAG_ACK     = 8'h10;
  localparam logic [15:0] PROTO_TCP    = 16'h0006;
  localparam logic [15:0] TCP_HDR_LEN  = 16'd20;
  localparam logic [15:0] DATA_OFFSET5 = 16'h5000;

  localparam logic SEG_SYN = 1'b0;
  localparam logic SEG_ACK = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT,
    PH_EST,
    PH_FAIL
  } phase_t;

  typedef struct packed {
    logic [AddrW-1:0]  local_address;
    logic [AddrW-1:0]  remote_address;
    logic [PortW-1:0]  local_port;
    logic [PortW-1:0]  remote_port;
    logic [SeqW-1:0]   initial_sequence;
    logic [SeqW-1:0]   final_sequence;
    logic [WinW-1:0]   window_size;
    logic [RetryW-1:0] retry_limit;
  } cfg_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [PortW-1:0] rx_source_port;
    logic [PortW-1:0] rx_dest_port;
    logic             rx_syn_flag;
    logic             rx_ack_flag;
    logic [SeqW-1:0]  rx_sequence;
    logic [SeqW-1:0]  rx_ack_number;
  } in_beat_t;

  typedef struct packed {
    logic              emit;
    logic              segment_kind;
    logic [SeqW-1:0]   tx_sequence;
    logic [SeqW-1:0]   tx_ack_number;
    logic [CsumW-1:0]  tx_checksum;
    phase_t            status;
    logic [RetryW-1:0] retries_used;
  } out_beat_t;

endpackage

### hdl/tcphs_if.sv
interface tcphs_in_if import tcphs_pkg::*;;
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [PortW-1:0] rx_source_port;
  logic [PortW-1:0] rx_dest_port;
  logic             rx_syn_flag;
  logic             rx_ack_flag;
  logic [SeqW-1:0]  rx_sequence;
  logic [SeqW-1:0]  rx_ack_number;

  modport source (
    output valid, kind, rx_source_port, rx_dest_port, rx_syn_flag, rx_ack_flag,
           rx_sequence, rx_ack_number,
    input  ready
  );
  modport sink (
    input  valid, kind, rx_source_port, rx_dest_port, rx_syn_flag, rx_ack_flag,
           rx_sequence, rx_ack_number,
    output ready
  );
endinterface

interface tcphs_out_if import tcphs_pkg::*;;
  logic              valid;
  logic              ready;
  logic              emit;
  logic              segment_kind;
  logic [SeqW-1:0]   tx_sequence;
  logic [SeqW-1:0]   tx_ack_number;
  logic [CsumW-1:0]  tx_checksum;
  logic [1:0]        status;
  logic [RetryW-1:0] retries_used;

  modport source (
    output valid, emit, segment_kind, tx_sequence, tx_ack_number, tx_checksum,
           status, retries_used,
    input  ready
  );
  modport sink (
    input  valid, emit, segment_kind, tx_sequence, tx_ack_number, tx_checksum,
           status, retries_used,
    output ready
  );
endinterface

interface tcphs_cfg_if import tcphs_pkg::*;;
  logic                valid;
  logic                ready;
  logic [RegIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/tcphs_cfg_regs.sv
module tcphs_cfg_regs import tcphs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  tcphs_cfg_if.sink   cfg_wr,
  output cfg_t        cfg
);

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.local_address    <= RST_LOCAL_ADDRESS;
      cfg.remote_address   <= RST_REMOTE_ADDRESS;
      cfg.local_port       <= RST_LOCAL_PORT;
      cfg.remote_port      <= RST_REMOTE_PORT;
      cfg.initial_sequence <= RST_INITIAL_SEQUENCE;
      cfg.final_sequence   <= RST_FINAL_SEQUENCE;
      cfg.window_size      <= RST_WINDOW_SIZE;
      cfg.retry_limit      <= RST_RETRY_LIMIT;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_LOCAL_ADDRESS:    cfg.local_address    <= cfg_wr.data;
        REG_REMOTE_ADDRESS:   cfg.remote_address   <= cfg_wr.data;
        REG_LOCAL_PORT:       cfg.local_port       <= cfg_wr.data[PortW-1:0];
        REG_REMOTE_PORT:      cfg.remote_port      <= cfg_wr.data[PortW-1:0];
        REG_INITIAL_SEQUENCE: cfg.initial_sequence <= cfg_wr.data;
        REG_FINAL_SEQUENCE:   cfg.final_sequence   <= cfg_wr.data;
        REG_WINDOW_SIZE:      cfg.window_size      <= cfg_wr.data[WinW-1:0];
        REG_RETRY_LIMIT:      cfg.retry_limit      <= cfg_wr.data[RetryW-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/tcphs_csum.sv
module tcphs_csum import tcphs_pkg::*; (
  input  cfg_t             cfg,
  input  logic [SeqW-1:0]  seq,
  input  logic [SeqW-1:0]  ack,
  input  logic [7:0]       flags,
  output logic [CsumW-1:0] csum
);

  // 14 words of 16 bits fit in 20 bits
  logic [19:0] sum;
  logic [16:0] fold1;
  logic [16:0] fold2;

  always_comb begin
    sum = 20'(cfg.local_address[31:16]) + 20'(cfg.local_address[15:0])
        + 20'(cfg.remote_address[31:16]) + 20'(cfg.remote_address[15:0])
        + 20'(PROTO_TCP) + 20'(TCP_HDR_LEN)
        + 20'(cfg.local_port) + 20'(cfg.remote_port)
        + 20'(seq[31:16]) + 20'(seq[15:0])
        + 20'(ack[31:16]) + 20'(ack[15:0])
        + 20'(DATA_OFFSET5 | {8'h00, flags})
        + 20'(cfg.window_size);
    fold1 = 17'(sum[19:16]) + 17'(sum[15:0]);
    fold2 = fold1 + 17'(fold1[16]);
    csum  = ~fold2[15:0];
  end

endmodule

### hdl/tcphs_core.sv
module tcphs_core import tcphs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  tcphs_in_if.sink    req,
  tcphs_out_if.source rsp
);

  logic              in_valid;
  in_beat_t          in_q;
  logic              out_valid;
  out_beat_t         out_q;
  phase_t            phase;
  logic [RetryW-1:0] retry_count;
  logic [SeqW-1:0]   peer_sequence;

  logic              out_load;
  logic              s1_go;
  phase_t            phase_next;
  logic [RetryW-1:0] retry_count_next;
  logic [SeqW-1:0]   peer_sequence_next;
  logic              emit;
  logic              skind;
  logic              seg_match;
  logic [SeqW-1:0]   seq_sel;
  logic [SeqW-1:0]   ack_sel;
  logic [7:0]        flags_sel;
  logic [CsumW-1:0]  csum;
  out_beat_t         out_next;

  assign out_load  = !out_valid || rsp.ready;
  assign s1_go     = in_valid && out_load;
  assign req.ready = !in_valid || out_load;

  assign seg_match = (phase == PH_WAIT)
                  && (in_q.rx_source_port == cfg.remote_port)
                  && (in_q.rx_dest_port == cfg.local_port)
                  && in_q.rx_syn_flag && in_q.rx_ack_flag
                  && (in_q.rx_ack_number == cfg.initial_sequence + 32'd1);

  always_comb begin
    phase_next         = phase;
    retry_count_next   = retry_count;
    peer_sequence_next = peer_sequence;
    emit               = 1'b0;
    skind              = SEG_SYN;
    case (in_q.kind)
      KIND_START: begin
        phase_next         = PH_WAIT;
        retry_count_next   = '0;
        peer_sequence_next = '0;
        emit               = 1'b1;
      end
      KIND_SEGMENT: begin
        if (seg_match) begin
          peer_sequence_next = in_q.rx_sequence;
          phase_next         = PH_EST;
          emit               = 1'b1;
          skind              = SEG_ACK;
        end
      end
      KIND_TIMEOUT: begin
        if (phase == PH_WAIT) begin
          if (retry_count != '1) retry_count_next = retry_count + 1'b1;
          emit = 1'b1;
          if (retry_count_next >= cfg.retry_limit) phase_next = PH_FAIL;
        end
      end
      default: ;
    endcase
  end

  assign seq_sel   = (skind == SEG_ACK) ? cfg.final_sequence : cfg.initial_sequence;
  assign ack_sel   = (skind == SEG_ACK) ? peer_sequence_next + 32'd1 : '0;
  assign flags_sel = (skind == SEG_ACK) ? FLAG_ACK : FLAG_SYN;

  tcphs_csum u_csum (
    .cfg   (cfg),
    .seq   (seq_sel),
    .ack   (ack_sel),
    .flags (flags_sel),
    .csum  (csum)
  );

  always_comb begin
    out_next.emit          = emit;
    out_next.segment_kind  = emit ? skind : 1'b0;
    out_next.tx_sequence   = emit ? seq_sel : '0;
    out_next.tx_ack_number = emit ? ack_sel : '0;
    out_next.tx_checksum   = emit ? csum : '0;
    out_next.status        = phase_next;
    out_next.retries_used  = retry_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      out_valid     <= 1'b0;
      phase         <= PH_IDLE;
      retry_count   <= '0;
      peer_sequence <= '0;
    end else begin
      if (req.valid && req.ready) begin
        in_valid <= 1'b1;
      end else if (s1_go) begin
        in_valid <= 1'b0;
      end
      if (s1_go) begin
        out_valid     <= 1'b1;
        phase         <= phase_next;
        retry_count   <= retry_count_next;
        peer_sequence <= peer_sequence_next;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_q.kind           <= req.kind;
      in_q.rx_source_port <= req.rx_source_port;
      in_q.rx_dest_port   <= req.rx_dest_port;
      in_q.rx_syn_flag    <= req.rx_syn_flag;
      in_q.rx_ack_flag    <= req.rx_ack_flag;
      in_q.rx_sequence    <= req.rx_sequence;
      in_q.rx_ack_number  <= req.rx_ack_number;
    end
    if (s1_go) out_q <= out_next;
  end

  assign rsp.valid         = out_valid;
  assign rsp.emit          = out_q.emit;
  assign rsp.segment_kind  = out_q.segment_kind;
  assign rsp.tx_sequence   = out_q.tx_sequence;
  assign rsp.tx_ack_number = out_q.tx_ack_number;
  assign rsp.tx_checksum   = out_q.tx_checksum;
  assign rsp.status        = out_q.status;
  assign rsp.retries_used  = out_q.retries_used;

  a_reset_idle: assert property (@(posedge clk)
    rst |=> phase == PH_IDLE && retry_count == '0 && !in_valid && !out_valid)
    else $error("state not cleared by reset");

  a_quiet_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_q.emit |->
      !out_q.segment_kind && out_q.tx_sequence == '0 &&
      out_q.tx_ack_number == '0 && out_q.tx_checksum == '0)
    else $error("payload not zero on quiet beat");

  a_ack_established: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_q.emit && out_q.segment_kind |-> out_q.status == PH_EST)
    else $error("ACK sent outside established");

  a_idle_no_retries: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> retry_count == '0)
    else $error("retries counted while idle");

  a_status_tracks: assert property (@(posedge clk) disable iff (rst)
    s1_go |=> out_q.status == phase && out_q.retries_used == retry_count)
    else $error("reported status differs from state");

endmodule

### hdl/tcp_handshake_initiator.sv
// TCP three-way handshake initiator, client side.
// Channels: req takes one event beat (start, received segment, timeout);
// rsp returns exactly one beat per event with the segment to send (if emit)
// and the resulting status and retry count. cfg writes one of eight registers
// (addresses, ports, sequences, window, retry limit) by index; indexes above
// seven are dropped. cfg is always ready; write only while no event is in
// flight.
// An accepted event waits in the input register; the state update and the
// checksum adder tree then settle into the result register.
// Throughput: one event per cycle while rsp does not stall, set by the single
// state update per beat.
// Reset (synchronous, rst high) loads the register defaults, returns the
// handshake to idle with zero retries and empties both stages.
// If rsp stalls, the result register holds its beat and the input register
// takes one more event; after that req.ready drops until rsp drains.
module tcp_handshake_initiator import tcphs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  tcphs_in_if.sink    req,
  tcphs_out_if.source rsp,
  tcphs_cfg_if.sink   cfg
);

  cfg_t regs;

  tcphs_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst    (rst),
    .cfg_wr (cfg),
    .cfg    (regs)
  );

  tcphs_core u_core (
    .clk (clk),
    .rst (rst),
    .cfg (regs),
    .req (req),
    .rsp (rsp)
  );

endmodule

### tb/tb_tcp_handshake_initiator.sv
module tb_tcp_handshake_initiator import tcphs_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KindW-1:0] KIND_UNUSED = 2'd3;
  localparam int CycleLimit = 400000;
  localparam int PhaseBeats = 225;
  localparam int RandomPhases = 6;

  class handshake_scoreboard;
    cfg_t              regs;
    phase_t            phase;
    logic [RetryW-1:0] retries;
    logic [SeqW-1:0]   peer_seq;
    out_beat_t         expected_segments[$];
    int                errors;
    int                beats_checked;

    function new(cfg_t start);
      regs = start;
      phase = PH_IDLE;
      retries = '0;
      peer_seq = '0;
      errors = 0;
      beats_checked = 0;
    endfunction

    task report(string msg);
      $display("ERROR @%0t beat %0d: %s", $realtime, beats_checked, msg);
      errors++;
    endtask

    function void write_register(logic [RegIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_LOCAL_ADDRESS:    regs.local_address = data[AddrW-1:0];
        REG_REMOTE_ADDRESS:   regs.remote_address = data[AddrW-1:0];
        REG_LOCAL_PORT:       regs.local_port = data[PortW-1:0];
        REG_REMOTE_PORT:      regs.remote_port = data[PortW-1:0];
        REG_INITIAL_SEQUENCE: regs.initial_sequence = data[SeqW-1:0];
        REG_FINAL_SEQUENCE:   regs.final_sequence = data[SeqW-1:0];
        REG_WINDOW_SIZE:      regs.window_size = data[WinW-1:0];
        REG_RETRY_LIMIT:      regs.retry_limit = data[RetryW-1:0];
        default: ;
      endcase
    endfunction

    // pseudo-header plus 20-byte header, 16-bit words, end-around carry
    function logic [CsumW-1:0] checksum(logic [SeqW-1:0] seq, logic [SeqW-1:0] ack,
                                        logic [7:0] flags);
      logic [31:0] acc;
      acc = 32'(regs.local_address[31:16]) + 32'(regs.local_address[15:0])
          + 32'(regs.remote_address[31:16]) + 32'(regs.remote_address[15:0])
          + 32'(PROTO_TCP) + 32'(TCP_HDR_LEN)
          + 32'(regs.local_port) + 32'(regs.remote_port)
          + 32'(seq[31:16]) + 32'(seq[15:0]) + 32'(ack[31:16]) + 32'(ack[15:0])
          + 32'(DATA_OFFSET5 | {8'h00, flags}) + 32'(regs.window_size);
      acc = 32'(acc[31:16]) + 32'(acc[15:0]);
      acc = acc + 32'(acc[31:16]);
      return ~acc[15:0];
    endfunction

    function void take_event(in_beat_t ev);
      out_beat_t seg;
      logic      syn_out;
      logic      ack_out;
      seg = '0;
      syn_out = 1'b0;
      ack_out = 1'b0;
      case (ev.kind)
        KIND_START: begin
          phase = PH_WAIT;
          retries = '0;
          peer_seq = '0;
          syn_out = 1'b1;
        end
        KIND_SEGMENT: begin
          if (phase == PH_WAIT && ev.rx_source_port == regs.remote_port &&
              ev.rx_dest_port == regs.local_port && ev.rx_syn_flag && ev.rx_ack_flag &&
              ev.rx_ack_number == regs.initial_sequence + 32'd1) begin
            peer_seq = ev.rx_sequence;
            phase = PH_EST;
            ack_out = 1'b1;
          end
        end
        KIND_TIMEOUT: begin
          if (phase == PH_WAIT) begin
            if (retries != '1) retries++;
            syn_out = 1'b1;
            if (retries >= regs.retry_limit) phase = PH_FAIL;
          end
        end
        default: ;
      endcase
      if (syn_out) begin
        seg.emit = 1'b1;
        seg.segment_kind = SEG_SYN;
        seg.tx_sequence = regs.initial_sequence;
        seg.tx_ack_number = '0;
        seg.tx_checksum = checksum(seg.tx_sequence, seg.tx_ack_number, FLAG_SYN);
      end else if (ack_out) begin
        seg.emit = 1'b1;
        seg.segment_kind = SEG_ACK;
        seg.tx_sequence = regs.final_sequence;
        seg.tx_ack_number = peer_seq + 32'd1;
        seg.tx_checksum = checksum(seg.tx_sequence, seg.tx_ack_number, FLAG_ACK);
      end
      seg.status = phase;
      seg.retries_used = retries;
      expected_segments.push_back(seg);
    endfunction

    task compare(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", field, got, want));
    endtask

    task check_segment(out_beat_t got);
      out_beat_t want;
      if (expected_segments.size() == 0) begin
        report("result beat with no event outstanding");
        return;
      end
      want = expected_segments.pop_front();
      compare("emit", got.emit, want.emit);
      compare("segment_kind", got.segment_kind, want.segment_kind);
      compare("tx_sequence", got.tx_sequence, want.tx_sequence);
      compare("tx_ack_number", got.tx_ack_number, want.tx_ack_number);
      compare("tx_checksum", got.tx_checksum, want.tx_checksum);
      compare("status", got.status, want.status);
      compare("retries_used", got.retries_used, want.retries_used);
      beats_checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  tcphs_in_if  req_if ();
  tcphs_out_if rsp_if ();
  tcphs_cfg_if cfg_if ();

  tcp_handshake_initiator uut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  handshake_scoreboard sb;
  cfg_t                active_cfg;
  bit                  send_calm;
  bit                  recv_calm;
  int                  beats_sent;
  int                  cycle_count = 0;
  in_beat_t            mon_ev;
  out_beat_t           mon_seg;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result first, so a beat can never match an event taken at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) begin
        mon_seg.emit = rsp_if.emit;
        mon_seg.segment_kind = rsp_if.segment_kind;
        mon_seg.tx_sequence = rsp_if.tx_sequence;
        mon_seg.tx_ack_number = rsp_if.tx_ack_number;
        mon_seg.tx_checksum = rsp_if.tx_checksum;
        mon_seg.status = phase_t'(rsp_if.status);
        mon_seg.retries_used = rsp_if.retries_used;
        sb.check_segment(mon_seg);
      end
      if (cfg_if.valid && cfg_if.ready) sb.write_register(cfg_if.index, cfg_if.data);
      if (req_if.valid && req_if.ready) begin
        mon_ev.kind = req_if.kind;
        mon_ev.rx_source_port = req_if.rx_source_port;
        mon_ev.rx_dest_port = req_if.rx_dest_port;
        mon_ev.rx_syn_flag = req_if.rx_syn_flag;
        mon_ev.rx_ack_flag = req_if.rx_ack_flag;
        mon_ev.rx_sequence = req_if.rx_sequence;
        mon_ev.rx_ack_number = req_if.rx_ack_number;
        sb.take_event(mon_ev);
      end
    end
  end

  initial begin
    int unsigned stall;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = recv_calm ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_if.valid) @(posedge clk);
    end
  end

  function automatic cfg_t default_regs();
    cfg_t c;
    c.local_address = RST_LOCAL_ADDRESS;
    c.remote_address = RST_REMOTE_ADDRESS;
    c.local_port = RST_LOCAL_PORT;
    c.remote_port = RST_REMOTE_PORT;
    c.initial_sequence = RST_INITIAL_SEQUENCE;
    c.final_sequence = RST_FINAL_SEQUENCE;
    c.window_size = RST_WINDOW_SIZE;
    c.retry_limit = RST_RETRY_LIMIT;
    return c;
  endfunction

  function automatic logic [SeqW-1:0] pick_seq();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_beat_t plain(logic [KindW-1:0] k);
    in_beat_t b;
    b.kind = k;
    b.rx_source_port = PortW'($urandom);
    b.rx_dest_port = PortW'($urandom);
    b.rx_syn_flag = 1'($urandom_range(0, 1));
    b.rx_ack_flag = 1'($urandom_range(0, 1));
    b.rx_sequence = pick_seq();
    b.rx_ack_number = pick_seq();
    return b;
  endfunction

  function automatic in_beat_t synack();
    in_beat_t b;
    b = plain(KIND_SEGMENT);
    b.rx_source_port = active_cfg.remote_port;
    b.rx_dest_port = active_cfg.local_port;
    b.rx_syn_flag = 1'b1;
    b.rx_ack_flag = 1'b1;
    b.rx_ack_number = active_cfg.initial_sequence + 32'd1;
    return b;
  endfunction

  function automatic in_beat_t damaged(in_beat_t b, int unsigned how);
    case (how)
      0: b.rx_source_port = b.rx_source_port ^ (16'd1 << $urandom_range(0, 15));
      1: b.rx_dest_port = b.rx_dest_port ^ (16'd1 << $urandom_range(0, 15));
      2: b.rx_syn_flag = 1'b0;
      3: b.rx_ack_flag = 1'b0;
      default: b.rx_ack_number = b.rx_ack_number ^ (32'd1 << $urandom_range(0, 31));
    endcase
    return b;
  endfunction

  function automatic in_beat_t noise();
    case ($urandom_range(0, 3))
      0: return synack();
      1: return plain(KindW'($urandom_range(0, 3)));
      2: return plain(KIND_TIMEOUT);
      default: return damaged(synack(), $urandom_range(0, 4));
    endcase
  endfunction

  function automatic cfg_t random_regs();
    cfg_t c;
    c.local_address = $urandom;
    c.remote_address = $urandom;
    c.local_port = PortW'($urandom);
    c.remote_port = PortW'($urandom);
    c.initial_sequence = pick_seq();
    c.final_sequence = pick_seq();
    c.window_size = WinW'($urandom);
    c.retry_limit = RetryW'($urandom_range(1, 15));
    return c;
  endfunction

  task automatic send(in_beat_t ev);
    int unsigned gap;
    gap = send_calm ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.kind <= ev.kind;
    req_if.rx_source_port <= ev.rx_source_port;
    req_if.rx_dest_port <= ev.rx_dest_port;
    req_if.rx_syn_flag <= ev.rx_syn_flag;
    req_if.rx_ack_flag <= ev.rx_ack_flag;
    req_if.rx_sequence <= ev.rx_sequence;
    req_if.rx_ack_number <= ev.rx_ack_number;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic wait_results();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_segments.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  // upper bits of narrow registers carry junk; one write goes to an unmapped index
  task automatic program_regs(cfg_t c);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(REG_LOCAL_ADDRESS, c.local_address);
    write_reg(REG_REMOTE_ADDRESS, c.remote_address);
    write_reg(REG_LOCAL_PORT, {junk[31:16], c.local_port});
    write_reg(REG_REMOTE_PORT, {junk[15:0], c.remote_port});
    write_reg(REG_INITIAL_SEQUENCE, c.initial_sequence);
    write_reg(REG_FINAL_SEQUENCE, c.final_sequence);
    write_reg(REG_WINDOW_SIZE, {junk[23:8], c.window_size});
    write_reg(REG_RETRY_LIMIT, {junk[31:4], c.retry_limit});
    write_reg(RegIdxW'(REG_RETRY_LIMIT + $urandom_range(1, 8)), $urandom);
    cfg_if.valid <= 1'b0;
    active_cfg = c;
  endtask

  task automatic directed();
    in_beat_t b;
    send(plain(KIND_TIMEOUT));
    send(synack());
    send(plain(KIND_UNUSED));
    send(plain(KIND_START));
    for (int i = 0; i < 5; i++) send(damaged(synack(), i));
    send(plain(KIND_TIMEOUT));
    b = synack();
    b.rx_sequence = '1;
    send(b);
    send(synack());
    send(plain(KIND_TIMEOUT));
    send(plain(KIND_START));
    repeat (3) send(plain(KIND_TIMEOUT));
    send(plain(KIND_TIMEOUT));
    send(plain(KIND_START));
    send(plain(KIND_TIMEOUT));
    send(plain(KIND_START));
    b = synack();
    b.rx_sequence = '0;
    send(b);
  endtask

  task automatic session();
    int unsigned timeouts;
    if ($urandom_range(0, 3) == 0) timeouts = $urandom_range(0, int'(active_cfg.retry_limit) + 1);
    else timeouts = $urandom_range(0, 1);
    send(plain(KIND_START));
    repeat (timeouts) begin
      if ($urandom_range(0, 3) == 0) send(damaged(synack(), $urandom_range(0, 4)));
      send(plain(KIND_TIMEOUT));
    end
    if ($urandom_range(0, 4) != 0) send(synack());
    repeat ($urandom_range(0, 2)) send(noise());
  endtask

  initial begin
    cfg_t c;
    int   phase_start;
    active_cfg = default_regs();
    sb = new(active_cfg);
    send_calm = 1'b0;
    recv_calm = 1'b0;
    beats_sent = 0;
    rst <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.kind <= KIND_START;
    req_if.rx_source_port <= '0;
    req_if.rx_dest_port <= '0;
    req_if.rx_syn_flag <= 1'b0;
    req_if.rx_ack_flag <= 1'b0;
    req_if.rx_sequence <= '0;
    req_if.rx_ack_number <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_LOCAL_ADDRESS;
    cfg_if.data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    directed();
    wait_results();

    // all ones, zero retry limit: first timeout fails, ack of SYN wraps to zero
    c = '1;
    c.retry_limit = '0;
    program_regs(c);
    send(plain(KIND_START));
    send(plain(KIND_TIMEOUT));
    send(plain(KIND_START));
    send(synack());
    wait_results();

    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0: c = '1;
        1: begin
          c = '0;
          c.retry_limit = RetryW'(1);
        end
        default: c = random_regs();
      endcase
      program_regs(c);
      phase_start = beats_sent;
      while (beats_sent - phase_start < PhaseBeats) begin
        send_calm = ($urandom_range(0, 4) == 0);
        recv_calm = ($urandom_range(0, 4) == 0);
        session();
        if ($urandom_range(0, 29) == 0) wait_results();
      end
      wait_results();
    end

    repeat (8) @(posedge clk);
    if (sb.expected_segments.size() != 0) sb.report("results missing at end of run");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
